@@ design/ffcr_pkg.sv @@
// Shared types and constants for the fixed-frame checksum receiver.
package ffcr_pkg;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd10;

  typedef struct packed {
    logic load;
    logic err;
  } ffcr_load_t;

endpackage

@@ design/ffcr_drain.sv @@
// Result buffer that holds one judged frame and hands it out one item per handshake.
module ffcr_drain #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffcr_pkg::ffcr_load_t            load_req,
  input  logic [PAYLOAD_BYTES-1:0][7:0]   frame_data,
  output logic                            busy,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,  // payload_byte[7:0], byte_index[10:8], zeros
  output logic                            m_tlast,
  output logic                            m_tuser   // status
);
  import ffcr_pkg::*;

  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  logic [PAYLOAD_BYTES-1:0][7:0] frame_buf;
  logic [IDX_W-1:0]              cnt;
  logic                          active;
  logic                          err;
  logic                          out_fire;
  logic                          is_last;
  logic [IDX_W+2:0]              cnt_ext;
  logic [7:0]                    out_byte;
  logic [2:0]                    out_index;

  assign out_fire = m_tvalid && m_tready;
  assign is_last  = err || (cnt == LAST_IDX);
  assign cnt_ext  = {3'b000, cnt};
  assign out_byte  = err ? 8'd0 : frame_buf[cnt];
  assign out_index = err ? 3'd0 : cnt_ext[2:0];

  assign busy     = active;
  assign m_tvalid = active;
  assign m_tlast  = is_last;
  assign m_tuser  = err ? STATUS_CSUM_ERR : STATUS_GOOD;
  assign m_tdata  = {5'b00000, out_index, out_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      err    <= 1'b0;
    end else if (load_req.load) begin
      active <= 1'b1;
      cnt    <= '0;
      err    <= load_req.err;
    end else if (out_fire) begin
      if (is_last) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_req.load) begin
      frame_buf <= frame_data;
    end
  end

`ifndef SYNTH
  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    load_req.load |-> !active)
    else $error("frame loaded while the previous one is still draining");

  a_err_single_item: assert property (@(posedge clk) disable iff (rst)
    (active && err) |-> (m_tlast && m_tdata[10:0] == 11'd0))
    else $error("error result is not a single zero item");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt <= LAST_IDX))
    else $error("drain count beyond the frame");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_fire && is_last && !load_req.load) |=> !active)
    else $error("buffer still busy after its last item");
`endif

endmodule

@@ design/fixed_frame_checksum_receiver_core.sv @@
// Top level of the fixed-frame checksum receiver: frame assembly, idle timeout and result stream.
//
// Each input item is either a received byte (s_tuser low) or a timer tick (s_tuser high) and is
// taken one per clock while s_tready is high. Bytes are gathered into frames of PAYLOAD_BYTES
// payload bytes plus one checksum byte that must equal their 8-bit wrapping sum. A good frame
// yields PAYLOAD_BYTES result items, one per cycle while m_tready is high, the last with m_tlast;
// a bad one yields a single item with status set. Judged frames are copied into a result buffer,
// so the next frame is collected while the previous one drains; s_tready drops only when a
// checksum byte is due and the buffer has not yet handed out its last item. Each byte reloads
// the idle counter from the configured timeout, each tick counts it down, and the first tick
// after it has reached zero drops any partial frame. The configuration channel is always ready.
module fixed_frame_checksum_receiver_core #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // idle_timeout_ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte
  input  logic        s_tuser,    // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // payload_byte[7:0], byte_index[10:8], zeros
  output logic        m_tlast,
  output logic        m_tuser     // status
);
  import ffcr_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PAYLOAD_BYTES);

  logic [PAYLOAD_BYTES-1:0][7:0] payload_store;
  logic [CNT_W-1:0]              bytes_held;
  logic [7:0]                    running_sum;
  logic [7:0]                    idle_count;
  logic                          flush_done;
  logic [7:0]                    idle_timeout;
  logic                          frame_full;
  logic                          drain_busy;
  logic                          in_fire;
  ffcr_load_t                    load_req;

  assign cfg_ready  = 1'b1;
  assign frame_full = (bytes_held == FULL_COUNT);
  assign s_tready   = !(frame_full && drain_busy);
  assign in_fire    = s_tvalid && s_tready;

  assign load_req.load = in_fire && (s_tuser == FUNC_BYTE) && frame_full;
  assign load_req.err  = (s_tdata != running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held  <= '0;
      running_sum <= 8'd0;
      idle_count  <= 8'd0;
      flush_done  <= 1'b0;
    end else if (in_fire) begin
      if (s_tuser == FUNC_TICK) begin
        if (idle_count != 8'd0) begin
          idle_count <= idle_count - 8'd1;
          flush_done <= 1'b0;
        end else if (!flush_done) begin
          bytes_held  <= '0;
          running_sum <= 8'd0;
          flush_done  <= 1'b1;
        end
      end else begin
        idle_count <= idle_timeout;
        if (!frame_full) begin
          running_sum <= running_sum + s_tdata;
          bytes_held  <= bytes_held + CNT_W'(1);
        end else begin
          running_sum <= 8'd0;
          bytes_held  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (s_tuser == FUNC_BYTE) && !frame_full) begin
      payload_store[bytes_held[IDX_W-1:0]] <= s_tdata;
    end
  end

  ffcr_drain #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .load_req   (load_req),
    .frame_data (payload_store),
    .busy       (drain_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

`ifndef SYNTH
  a_held_in_range: assert property (@(posedge clk) disable iff (rst)
    bytes_held <= FULL_COUNT)
    else $error("more bytes held than a frame has");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == FUNC_TICK && idle_count == 8'd0 && !flush_done)
      |=> (bytes_held == '0 && running_sum == 8'd0 && flush_done))
    else $error("idle flush did not drop the partial frame");

  a_byte_reloads: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == FUNC_BYTE) |=> (idle_count == $past(idle_timeout)))
    else $error("received byte did not reload the idle counter");
`endif

endmodule
